/* src/prad_pkg.sv */
package prad_pkg;

  // Field widths of the bus item and the result item
  localparam int CMD_W    = 3;
  localparam int ADDR_W   = 16;
  localparam int BYTE_W   = 8;
  localparam int INDEX_W  = 6;
  localparam int KIND_W   = 3;
  localparam int REGION_W = 5;

  // Default sizes handed to the top level
  localparam int DEFAULT_REGION_SLOTS = 32;
  localparam int DEFAULT_RAM_BYTES    = 65536;

  // Address reduction modulo the RAM size: quotient by reciprocal multiply
  localparam int RECIP_SHIFT = 32;
  localparam int RECIP_W     = 25;
  localparam int QUOT_W      = 9;
  localparam int REM_W       = QUOT_W + 17;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_READ_BYTE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE_BYTE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_READ_WORD  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_WRITE_WORD = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DEFINE     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SET_ACTIVE = 3'd5;

  // Result kind codes
  localparam logic [KIND_W-1:0] KIND_RAM_DATA     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RAM_WRITTEN  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REGION_READ  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REGION_WRITE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DEFINED      = 3'd4;
  localparam logic [KIND_W-1:0] KIND_FULL         = 3'd5;
  localparam logic [KIND_W-1:0] KIND_FLAG_SET     = 3'd6;
  localparam logic [KIND_W-1:0] KIND_BAD_INDEX    = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [ADDR_W-1:0]  address;
    logic [ADDR_W-1:0]  value;
    logic [ADDR_W-1:0]  region_low;
    logic [ADDR_W-1:0]  region_high;
    logic [INDEX_W-1:0] region_index;
    logic               active;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [REGION_W-1:0] region;
    logic [ADDR_W-1:0]   offset;
    logic [BYTE_W-1:0]   data;
    logic                last;
  } out_item_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic reduce;
    logic hi;
    logic lookup;
    logic emit_byte;
    logic emit_table;
    logic clear;
    logic last;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic slot_free;
    logic clear_done;
  } dp_status_t;

endpackage

/* src/prad_if.sv */
interface prad_in_if;
  logic                            valid;
  logic                            ready;
  logic [prad_pkg::CMD_W-1:0]      cmd;
  logic [prad_pkg::ADDR_W-1:0]     address;
  logic [prad_pkg::ADDR_W-1:0]     value;
  logic [prad_pkg::ADDR_W-1:0]     region_low;
  logic [prad_pkg::ADDR_W-1:0]     region_high;
  logic [prad_pkg::INDEX_W-1:0]    region_index;
  logic                            active;

  modport source (output valid, cmd, address, value, region_low, region_high,
                  region_index, active, input ready);
  modport sink (input valid, cmd, address, value, region_low, region_high,
                region_index, active, output ready);
endinterface

interface prad_out_if;
  logic                            valid;
  logic                            ready;
  logic [prad_pkg::KIND_W-1:0]     kind;
  logic [prad_pkg::REGION_W-1:0]   region;
  logic [prad_pkg::ADDR_W-1:0]     offset;
  logic [prad_pkg::BYTE_W-1:0]     data;
  logic                            last;

  modport source (output valid, kind, region, offset, data, last, input ready);
  modport sink (input valid, kind, region, offset, data, last, output ready);
endinterface

/* src/prad_ram.sv */
module prad_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on we, register read data on re
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

/* src/prad_datapath.sv */
module prad_datapath #(
  parameter int REGION_SLOTS = prad_pkg::DEFAULT_REGION_SLOTS,
  parameter int RAM_BYTES    = prad_pkg::DEFAULT_RAM_BYTES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  prad_pkg::in_item_t   in_item,
  input  prad_pkg::dp_cmd_t    cmd,
  input  logic                 out_ready,
  output prad_pkg::dp_status_t status,
  output prad_pkg::out_item_t  out_item,
  output logic                 out_valid
);

  localparam int SLOT_W = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
  localparam int CNT_W  = $clog2(REGION_SLOTS + 1);
  localparam int RAM_AW = $clog2(RAM_BYTES);
  localparam int PROD_W = prad_pkg::ADDR_W + prad_pkg::RECIP_W;
  localparam logic [prad_pkg::RECIP_W-1:0] RECIP = prad_pkg::RECIP_W'(
    ((64'd1 << prad_pkg::RECIP_SHIFT) + 64'(RAM_BYTES) - 64'd1) / 64'(RAM_BYTES));

  prad_pkg::in_item_t            item_q;
  logic [prad_pkg::ADDR_W-1:0]   window_base  [REGION_SLOTS];
  logic [prad_pkg::ADDR_W-1:0]   window_limit [REGION_SLOTS];
  logic [REGION_SLOTS-1:0]       window_enabled;
  logic [CNT_W-1:0]              region_count;

  logic [prad_pkg::ADDR_W-1:0]   a_addr;
  logic [prad_pkg::BYTE_W-1:0]   a_byte;
  logic [PROD_W-1:0]             a_prod;
  logic [REGION_SLOTS-1:0]       a_match;
  logic [prad_pkg::ADDR_W-1:0]   cur_addr;
  logic [prad_pkg::BYTE_W-1:0]   cur_byte;
  logic [prad_pkg::QUOT_W-1:0]   quot;
  logic [REGION_SLOTS-1:0]       match;

  logic [prad_pkg::REM_W-1:0]    b_rem;
  logic [SLOT_W-1:0]             b_win;
  logic                          b_hit;
  logic [RAM_AW-1:0]             ram_addr;
  logic [SLOT_W-1:0]             win;
  logic                          hit;

  logic                          is_write;
  logic                          is_define;
  logic                          table_full;
  logic                          bad_index;
  logic [SLOT_W-1:0]             new_slot;
  logic [SLOT_W-1:0]             flag_slot;
  logic [RAM_AW-1:0]             clear_cnt;
  logic                          ram_we;
  logic                          ram_re;
  logic [RAM_AW-1:0]             ram_a;
  logic [prad_pkg::BYTE_W-1:0]   ram_wdata;
  logic [prad_pkg::BYTE_W-1:0]   ram_rdata;
  logic                          load_out;
  prad_pkg::out_item_t           out_next;

  assign is_write  = (item_q.cmd == prad_pkg::CMD_WRITE_BYTE) ||
                     (item_q.cmd == prad_pkg::CMD_WRITE_WORD);
  assign is_define = (item_q.cmd == prad_pkg::CMD_DEFINE);
  assign table_full = (region_count == CNT_W'(REGION_SLOTS));
  assign bad_index  = (item_q.region_index >= prad_pkg::INDEX_W'(region_count));
  assign new_slot   = region_count[SLOT_W-1:0];
  assign flag_slot  = item_q.region_index[SLOT_W-1:0];

  // Stage A: pick the byte, start the modulo reduction, compare all windows
  assign a_addr = item_q.address + prad_pkg::ADDR_W'(cmd.hi);
  assign a_byte = cmd.hi ? item_q.value[prad_pkg::ADDR_W-1:prad_pkg::BYTE_W]
                         : item_q.value[prad_pkg::BYTE_W-1:0];
  assign a_prod = PROD_W'(a_addr) * PROD_W'(RECIP);

  always_comb begin
    for (int i = 0; i < REGION_SLOTS; i++) begin
      a_match[i] = window_enabled[i] && (a_addr >= window_base[i]) &&
                   (a_addr <= window_limit[i]);
    end
  end

  // Stage B: finish the remainder, lowest matching slot wins
  assign b_rem = prad_pkg::REM_W'(cur_addr) -
                 prad_pkg::REM_W'(quot) * prad_pkg::REM_W'(RAM_BYTES);

  always_comb begin
    b_win = '0;
    b_hit = 1'b0;
    for (int i = REGION_SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        b_win = SLOT_W'(i);
        b_hit = 1'b1;
      end
    end
  end

  // Build the result item
  always_comb begin
    out_next = '0;
    out_next.last = cmd.last;
    if (cmd.emit_byte) begin
      if (hit) begin
        out_next.kind   = is_write ? prad_pkg::KIND_REGION_WRITE
                                   : prad_pkg::KIND_REGION_READ;
        out_next.region = prad_pkg::REGION_W'(win);
        out_next.offset = cur_addr - window_base[win];
        out_next.data   = is_write ? cur_byte : '0;
      end else begin
        out_next.kind = is_write ? prad_pkg::KIND_RAM_WRITTEN : prad_pkg::KIND_RAM_DATA;
        out_next.data = is_write ? cur_byte : ram_rdata;
      end
    end else if (is_define) begin
      if (table_full) begin
        out_next.kind = prad_pkg::KIND_FULL;
      end else begin
        out_next.kind   = prad_pkg::KIND_DEFINED;
        out_next.region = prad_pkg::REGION_W'(region_count);
      end
    end else begin
      if (bad_index) begin
        out_next.kind = prad_pkg::KIND_BAD_INDEX;
      end else begin
        out_next.kind   = prad_pkg::KIND_FLAG_SET;
        out_next.region = prad_pkg::REGION_W'(flag_slot);
      end
    end
  end

  // RAM port: clearing sweep, write on emit, read on lookup
  assign ram_we    = cmd.clear || (cmd.emit_byte && is_write && !hit);
  assign ram_re    = cmd.lookup;
  assign ram_wdata = cmd.clear ? '0 : cur_byte;
  always_comb begin
    if (cmd.clear) begin
      ram_a = clear_cnt;
    end else if (cmd.emit_byte) begin
      ram_a = ram_addr;
    end else begin
      ram_a = b_rem[RAM_AW-1:0];
    end
  end

  prad_ram #(
    .WIDTH (prad_pkg::BYTE_W),
    .DEPTH (RAM_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_a),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_q <= in_item;
    end
    if (cmd.reduce) begin
      cur_addr <= a_addr;
      cur_byte <= a_byte;
      quot     <= a_prod[prad_pkg::RECIP_SHIFT +: prad_pkg::QUOT_W];
      match    <= a_match;
    end
    if (cmd.lookup) begin
      ram_addr <= b_rem[RAM_AW-1:0];
      win      <= b_win;
      hit      <= b_hit;
    end
    if (cmd.emit_table && is_define && !table_full) begin
      window_base[new_slot]  <= item_q.region_low;
      window_limit[new_slot] <= item_q.region_high;
    end
    if (load_out) begin
      out_item <= out_next;
    end
  end

  // Control state: region table flags, output slot, clearing counter
  assign load_out = cmd.emit_byte || cmd.emit_table;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_enabled <= '0;
      region_count   <= '0;
      out_valid      <= 1'b0;
      clear_cnt      <= '0;
    end else begin
      if (cmd.emit_table) begin
        if (is_define) begin
          if (!table_full) begin
            window_enabled[new_slot] <= 1'b0;
            region_count             <= region_count + CNT_W'(1);
          end
        end else if (!bad_index) begin
          window_enabled[flag_slot] <= item_q.active;
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.clear) begin
        clear_cnt <= clear_cnt + RAM_AW'(1);
      end
    end
  end

  assign status.slot_free  = !out_valid || out_ready;
  assign status.clear_done = (clear_cnt == RAM_AW'(RAM_BYTES - 1));

  a_load_into_free_slot: assert property (@(posedge clk) disable iff (rst)
    load_out |-> status.slot_free)
    else $error("result loaded while output slot still held");

  a_winner_enabled: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_byte && hit) |-> window_enabled[win])
    else $error("winning window is not enabled");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    region_count <= CNT_W'(REGION_SLOTS))
    else $error("region count beyond table size");

endmodule

/* src/prad_ctrl.sv */
module prad_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [prad_pkg::CMD_W-1:0] in_cmd,
  input  prad_pkg::dp_status_t       status,
  output logic                       ready,
  output prad_pkg::dp_cmd_t          cmd
);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_REDUCE = 6'b000100,
    ST_LOOKUP = 6'b001000,
    ST_EMIT   = 6'b010000,
    ST_TABLE  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   word;
  logic   word_next;
  logic   hi;
  logic   hi_next;

  assign ready = (state == ST_IDLE);

  // Sequence each item through the datapath
  always_comb begin
    state_next = state;
    word_next  = word;
    hi_next    = hi;
    cmd        = '0;
    cmd.hi     = hi;
    cmd.last   = !word || hi;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          hi_next  = 1'b0;
          unique case (in_cmd) inside
            prad_pkg::CMD_READ_BYTE, prad_pkg::CMD_WRITE_BYTE: begin
              word_next  = 1'b0;
              state_next = ST_REDUCE;
            end
            prad_pkg::CMD_READ_WORD, prad_pkg::CMD_WRITE_WORD: begin
              word_next  = 1'b1;
              state_next = ST_REDUCE;
            end
            prad_pkg::CMD_DEFINE, prad_pkg::CMD_SET_ACTIVE: begin
              word_next  = 1'b0;
              state_next = ST_TABLE;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_REDUCE: begin
        cmd.reduce = 1'b1;
        state_next = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.slot_free) begin
          cmd.emit_byte = 1'b1;
          if (word && !hi) begin
            hi_next    = 1'b1;
            state_next = ST_REDUCE;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_TABLE: begin
        if (status.slot_free) begin
          cmd.emit_table = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      word  <= 1'b0;
      hi    <= 1'b0;
    end else begin
      state <= state_next;
      word  <= word_next;
      hi    <= hi_next;
    end
  end

  a_high_byte_follows: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_byte && !cmd.last) |=> (cmd.reduce && cmd.hi))
    else $error("high byte of a word access did not follow the low byte");

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |-> (!ready && !cmd.load))
    else $error("item taken during RAM clearing sweep");

endmodule

/* src/priority_region_address_decoder_unit.sv */
// Priority region address decoder: a bus item goes to the lowest-numbered
// enabled window that holds its address, otherwise to the backing RAM. After
// reset the block sweeps the RAM to zero, one byte a cycle, and takes no item
// until the sweep is done. A byte read or write goes through accept, window
// compare with address reduction, RAM read with priority select, and result
// (held until the output slot is free); a word access runs these steps for the
// low byte, then the high byte. A region command goes from accept to result, and
// an unused command code is accepted with no result. Both bytes of a word share
// the single-port RAM; the compare over the window table is registered. A result
// may wait in the output register while the next item is accepted.
module priority_region_address_decoder_unit #(
  parameter int REGION_SLOTS = prad_pkg::DEFAULT_REGION_SLOTS,
  parameter int RAM_BYTES    = prad_pkg::DEFAULT_RAM_BYTES
) (
  input logic             clk,
  input logic             rst,
  prad_in_if.sink         bus,
  prad_out_if.source      result
);

  prad_pkg::in_item_t   in_item;
  prad_pkg::out_item_t  out_item;
  prad_pkg::dp_cmd_t    cmd;
  prad_pkg::dp_status_t status;
  logic                 ready;
  logic                 out_valid;

  // Gather the bus fields into one item
  assign in_item.cmd          = bus.cmd;
  assign in_item.address      = bus.address;
  assign in_item.value        = bus.value;
  assign in_item.region_low   = bus.region_low;
  assign in_item.region_high  = bus.region_high;
  assign in_item.region_index = bus.region_index;
  assign in_item.active       = bus.active;
  assign bus.ready            = ready;

  prad_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (bus.valid),
    .in_cmd   (bus.cmd),
    .status   (status),
    .ready    (ready),
    .cmd      (cmd)
  );

  prad_datapath #(
    .REGION_SLOTS (REGION_SLOTS),
    .RAM_BYTES    (RAM_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cmd       (cmd),
    .out_ready (result.ready),
    .status    (status),
    .out_item  (out_item),
    .out_valid (out_valid)
  );

  // Drive the result channel from the output register
  assign result.valid  = out_valid;
  assign result.kind   = out_item.kind;
  assign result.region = out_item.region;
  assign result.offset = out_item.offset;
  assign result.data   = out_item.data;
  assign result.last   = out_item.last;

endmodule

/* tb/priority_region_address_decoder_unit_test.sv */
module priority_region_address_decoder_unit_test;

  localparam int REGION_SLOTS = prad_pkg::DEFAULT_REGION_SLOTS;
  localparam int RAM_BYTES    = prad_pkg::DEFAULT_RAM_BYTES;
  localparam int BUS_ITEMS    = 900;
  // The RAM sweep after reset moves no item, so it counts toward the quiet cycles
  localparam int QUIET_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 16;
  localparam logic [7:0] HOT_PAGES [5] = '{8'h00, 8'h12, 8'h3C, 8'hA5, 8'hFF};

  logic clk;
  logic rst;

  prad_in_if  bus_if ();
  prad_out_if res_if ();

  priority_region_address_decoder_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .bus    (bus_if),
    .result (res_if)
  );

  // Mirror of the decoder state
  bit [7:0]  ram_mirror [RAM_BYTES];
  bit [15:0] win_base [REGION_SLOTS];
  bit [15:0] win_limit [REGION_SLOTS];
  bit        win_on [REGION_SLOTS];
  int        win_count;

  prad_pkg::in_item_t  bus_items [$];
  prad_pkg::out_item_t bus_results_due [$];

  int errors;
  int send_wait;
  int send_calm;
  int take_wait;
  int take_calm;
  int quiet_cycles;

  // Mostly a fresh gap drawn at random, now and then a run of back-to-back items
  function automatic int draw_gap(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  // Lowest-numbered enabled window holding the address, -1 for none
  function automatic int hit_slot(bit [15:0] addr);
    for (int i = 0; i < win_count; i++) begin
      if (win_on[i] && addr >= win_base[i] && addr <= win_limit[i]) return i;
    end
    return -1;
  endfunction

  function automatic void byte_access(bit [15:0] addr, bit write, bit [7:0] wdata, bit last);
    prad_pkg::out_item_t r;
    int slot;
    r = '0;
    r.last = last;
    slot = hit_slot(addr);
    if (slot >= 0) begin
      r.kind   = write ? prad_pkg::KIND_REGION_WRITE : prad_pkg::KIND_REGION_READ;
      r.region = prad_pkg::REGION_W'(slot);
      r.offset = 16'(addr - win_base[slot]);
      r.data   = write ? wdata : 8'h00;
    end else if (write) begin
      ram_mirror[addr % RAM_BYTES] = wdata;
      r.kind = prad_pkg::KIND_RAM_WRITTEN;
      r.data = wdata;
    end else begin
      r.kind = prad_pkg::KIND_RAM_DATA;
      r.data = ram_mirror[addr % RAM_BYTES];
    end
    bus_results_due.push_back(r);
  endfunction

  // Advance the mirror by one accepted item and queue what it must produce
  function automatic void decode_bus_item(prad_pkg::in_item_t it);
    prad_pkg::out_item_t r;
    bit [15:0] next_addr;
    r = '0;
    r.last = 1'b1;
    next_addr = it.address + 16'd1;
    case (it.cmd)
      prad_pkg::CMD_READ_BYTE:  byte_access(it.address, 1'b0, 8'h00, 1'b1);
      prad_pkg::CMD_WRITE_BYTE: byte_access(it.address, 1'b1, it.value[7:0], 1'b1);
      prad_pkg::CMD_READ_WORD: begin
        byte_access(it.address, 1'b0, 8'h00, 1'b0);
        byte_access(next_addr, 1'b0, 8'h00, 1'b1);
      end
      prad_pkg::CMD_WRITE_WORD: begin
        byte_access(it.address, 1'b1, it.value[7:0], 1'b0);
        byte_access(next_addr, 1'b1, it.value[15:8], 1'b1);
      end
      prad_pkg::CMD_DEFINE: begin
        if (win_count >= REGION_SLOTS) begin
          r.kind = prad_pkg::KIND_FULL;
        end else begin
          win_base[win_count]  = it.region_low;
          win_limit[win_count] = it.region_high;
          win_on[win_count]    = 1'b0;
          r.kind   = prad_pkg::KIND_DEFINED;
          r.region = prad_pkg::REGION_W'(win_count);
          win_count++;
        end
        bus_results_due.push_back(r);
      end
      prad_pkg::CMD_SET_ACTIVE: begin
        if (it.region_index >= win_count) begin
          r.kind = prad_pkg::KIND_BAD_INDEX;
        end else begin
          win_on[it.region_index] = it.active;
          r.kind   = prad_pkg::KIND_FLAG_SET;
          r.region = prad_pkg::REGION_W'(it.region_index);
        end
        bus_results_due.push_back(r);
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 'h%0h, actual 'h%0h", name, want, got);
      errors++;
    end
  endfunction

  function automatic prad_pkg::in_item_t random_item();
    prad_pkg::in_item_t it;
    it.cmd          = prad_pkg::CMD_W'($urandom_range(0, 7));
    it.address      = prad_pkg::ADDR_W'($urandom);
    it.value        = prad_pkg::ADDR_W'($urandom);
    it.region_low   = prad_pkg::ADDR_W'($urandom);
    it.region_high  = prad_pkg::ADDR_W'($urandom);
    it.region_index = prad_pkg::INDEX_W'($urandom);
    it.active       = 1'($urandom);
    return it;
  endfunction

  function automatic void push_item(logic [prad_pkg::CMD_W-1:0] cmd, logic [15:0] address,
                                    logic [15:0] value, logic [15:0] low, logic [15:0] high,
                                    logic [prad_pkg::INDEX_W-1:0] index, logic active);
    prad_pkg::in_item_t it;
    it.cmd          = cmd;
    it.address      = address;
    it.value        = value;
    it.region_low   = low;
    it.region_high  = high;
    it.region_index = index;
    it.active       = active;
    bus_items.push_back(it);
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Reset, stimulus and end of run
  initial begin
    prad_pkg::in_item_t it;
    int counted;
    int defines_sent;
    int pick;
    int shape;
    int top_index;

    rst = 1'b1;
    bus_if.valid        = 1'b0;
    bus_if.cmd          = '0;
    bus_if.address      = '0;
    bus_if.value        = '0;
    bus_if.region_low   = '0;
    bus_if.region_high  = '0;
    bus_if.region_index = '0;
    bus_if.active       = 1'b0;
    res_if.ready        = 1'b0;
    errors    = 0;
    win_count = 0;
    send_calm = 0;
    take_calm = 0;
    quiet_cycles = 0;

    // Word accesses across the top of the address space, empty table
    push_item(prad_pkg::CMD_READ_BYTE,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 6'd0,  1'b0);
    push_item(prad_pkg::CMD_WRITE_BYTE, 16'hFFFF, 16'hA5C3, 16'h0000, 16'h0000, 6'd0,  1'b0);
    push_item(prad_pkg::CMD_READ_WORD,  16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 6'd0,  1'b0);
    push_item(prad_pkg::CMD_WRITE_WORD, 16'hFFFF, 16'h5AFF, 16'h0000, 16'h0000, 6'd0,  1'b0);
    push_item(prad_pkg::CMD_READ_WORD,  16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 6'd0,  1'b0);
    push_item(prad_pkg::CMD_SET_ACTIVE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 6'd0,  1'b1);
    // Overlapping windows, an empty window and one spanning everything
    push_item(prad_pkg::CMD_DEFINE,     16'h0000, 16'h0000, 16'h1200, 16'h12FF, 6'd0,  1'b0);
    push_item(prad_pkg::CMD_DEFINE,     16'h0000, 16'h0000, 16'h1280, 16'h1300, 6'd0,  1'b0);
    push_item(prad_pkg::CMD_DEFINE,     16'h0000, 16'h0000, 16'h8000, 16'h7FFF, 6'd0,  1'b0);
    push_item(prad_pkg::CMD_DEFINE,     16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 6'd0,  1'b0);
    push_item(prad_pkg::CMD_SET_ACTIVE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 6'd1,  1'b1);
    push_item(prad_pkg::CMD_WRITE_BYTE, 16'h1290, 16'h0077, 16'h0000, 16'h0000, 6'd0,  1'b0);
    push_item(prad_pkg::CMD_SET_ACTIVE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 6'd0,  1'b1);
    push_item(prad_pkg::CMD_READ_BYTE,  16'h1290, 16'h0000, 16'h0000, 16'h0000, 6'd0,  1'b0);
    push_item(prad_pkg::CMD_SET_ACTIVE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 6'd2,  1'b1);
    push_item(prad_pkg::CMD_READ_WORD,  16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 6'd0,  1'b0);
    push_item(prad_pkg::CMD_SET_ACTIVE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 6'd63, 1'b1);
    push_item(prad_pkg::CMD_SET_ACTIVE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 6'd4,  1'b0);
    // Unused command codes
    push_item(3'd6,                     16'h0000, 16'h0000, 16'h0000, 16'h0000, 6'd0,  1'b0);
    push_item(3'd7,                     16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd63, 1'b1);
    push_item(prad_pkg::CMD_SET_ACTIVE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 6'd3,  1'b1);
    push_item(prad_pkg::CMD_WRITE_WORD, 16'h12FF, 16'hBEEF, 16'h0000, 16'h0000, 6'd0,  1'b0);
    push_item(prad_pkg::CMD_READ_BYTE,  16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 6'd0,  1'b0);
    push_item(prad_pkg::CMD_SET_ACTIVE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 6'd3,  1'b0);
    push_item(prad_pkg::CMD_SET_ACTIVE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 6'd0,  1'b0);

    // Random part: mostly accesses on a few hot pages, windows defined on some of them
    counted = 0;
    defines_sent = 4;
    while (counted < BUS_ITEMS) begin
      it = random_item();
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        it.cmd = prad_pkg::CMD_DEFINE;
        shape = $urandom_range(0, 9);
        if (shape < 8) begin
          it.region_low = {HOT_PAGES[1 + 2 * $urandom_range(0, 1) + $urandom_range(0, 1)],
                           8'($urandom)};
          if (shape < 7) it.region_high = it.region_low + 16'($urandom_range(0, 63));
          else it.region_high = it.region_low - 16'($urandom_range(1, 200));
        end
        defines_sent++;
        counted++;
      end else if (pick < 20) begin
        it.cmd = prad_pkg::CMD_SET_ACTIVE;
        top_index = (defines_sent < REGION_SLOTS) ? defines_sent : REGION_SLOTS;
        if ($urandom_range(0, 4) != 0)
          it.region_index = prad_pkg::INDEX_W'($urandom_range(0, top_index));
        it.active = ($urandom_range(0, 9) < 7);
        counted++;
      end else if (pick < 23) begin
        it.cmd = prad_pkg::CMD_W'($urandom_range(6, 7));
      end else begin
        it.cmd = prad_pkg::CMD_W'($urandom_range(0, 3));
        if ($urandom_range(0, 4) != 0)
          it.address = {HOT_PAGES[$urandom_range(0, 4)], 8'($urandom)};
        counted++;
      end
      bus_items.push_back(it);
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (bus_items.size() > 0 || bus_if.valid || bus_results_due.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("priority_region_address_decoder_unit_test passed");
    else
      $display("priority_region_address_decoder_unit_test failed");
    $finish;
  end

  // Bus driver: hold an item until accepted, then wait a drawn gap
  always @(posedge clk) begin
    if (rst) begin
      bus_if.valid <= 1'b0;
      send_wait = draw_gap(send_calm);
    end else if (!bus_if.valid || bus_if.ready) begin
      if (bus_if.valid) begin
        decode_bus_item(bus_items.pop_front());
        send_wait = draw_gap(send_calm);
      end
      if (send_wait > 0) begin
        send_wait--;
        bus_if.valid <= 1'b0;
      end else if (bus_items.size() > 0) begin
        bus_if.valid        <= 1'b1;
        bus_if.cmd          <= bus_items[0].cmd;
        bus_if.address      <= bus_items[0].address;
        bus_if.value        <= bus_items[0].value;
        bus_if.region_low   <= bus_items[0].region_low;
        bus_if.region_high  <= bus_items[0].region_high;
        bus_if.region_index <= bus_items[0].region_index;
        bus_if.active       <= bus_items[0].active;
      end else begin
        bus_if.valid <= 1'b0;
      end
    end
  end

  // Result monitor: check each item against the oldest due result, then wait a drawn gap
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
      take_wait = draw_gap(take_calm);
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (bus_results_due.size() == 0) begin
          $error("result item with none due: kind 'h%0h region 'h%0h offset 'h%0h data 'h%0h",
                 res_if.kind, res_if.region, res_if.offset, res_if.data);
          errors++;
        end else begin
          check_field("kind",   bus_results_due[0].kind,   res_if.kind);
          check_field("region", bus_results_due[0].region, res_if.region);
          check_field("offset", bus_results_due[0].offset, res_if.offset);
          check_field("data",   bus_results_due[0].data,   res_if.data);
          check_field("last",   bus_results_due[0].last,   res_if.last);
          void'(bus_results_due.pop_front());
        end
        take_wait = draw_gap(take_calm);
      end
      if (take_wait > 0) begin
        take_wait--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: drop the run after too long without any item moving
  always @(posedge clk) begin
    if ((bus_if.valid && bus_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("priority_region_address_decoder_unit_test failed");
        $finish;
      end
    end
  end

endmodule

/* priority_region_address_decoder_unit.f */
src/prad_pkg.sv
src/prad_if.sv
src/prad_ram.sv
src/prad_datapath.sv
src/prad_ctrl.sv
src/priority_region_address_decoder_unit.sv
tb/priority_region_address_decoder_unit_test.sv
